// ===== hw/rtl/rpn_pkg.sv =====
package rpn_pkg;

  // Default build values
  localparam int STACK_DEPTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // Word widths
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;

  // Iterations of the shift-add multiply and of the restoring divide
  localparam int ALU_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(ALU_STEPS);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Token kinds
  typedef enum logic [KIND_W-1:0] {
    K_NUM     = 3'd0,
    K_ADD     = 3'd1,
    K_SUB     = 3'd2,
    K_MUL     = 3'd3,
    K_DIV     = 3'd4,
    K_END     = 3'd5,
    K_INVALID = 3'd6
  } kind_t;

  // Result status codes, also used for the sticky error
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_INVALID   = 3'd4,
    ST_TOO_MANY  = 3'd5,
    ST_TOO_FEW   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_MULT,
    ALU_DIVIDE,
    ALU_FIN
  } alu_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_R,
    S_RD_L,
    S_EXEC,
    S_WAIT,
    S_END
  } seq_state_t;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

// ===== hw/rtl/rpn_stack.sv =====
module rpn_stack import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [STACK_DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rpn_alu.sv =====
module rpn_alu import rpn_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  alu_req_t                 req,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     done,
  output logic signed [DATA_W-1:0] res
);

  alu_state_t state, state_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [2*DATA_W-1:0] work, work_next;
  logic [DATA_W-1:0]   opnd, opnd_next;
  logic neg, neg_next;
  logic ovf, ovf_next;
  logic is_mul, is_mul_next;
  logic done_next;
  logic signed [DATA_W-1:0] res_next;

  logic [DATA_W-1:0]   mag_a, mag_b;
  logic [2*DATA_W-1:0] num;
  logic [DATA_W:0]     op_a, op_b;
  logic                sub;
  logic [DATA_W+1:0]   sum;
  logic                borrow;
  logic [2*DATA_W-1:0] mag;
  logic                sat;

  // Operand magnitudes and the scaled dividend
  assign mag_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign mag_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign num   = (2*DATA_W)'(mag_a) << FRACTION_BITS;

  // Shared adder input selection
  always_comb begin
    op_a = {a[DATA_W-1], a};
    op_b = {b[DATA_W-1], b};
    sub  = 1'b0;
    unique case (state)
      ALU_IDLE: begin
        if (req.op == ALU_DIV) begin
          // high half of the dividend against the divisor: quotient overflow
          op_a = {1'b0, num[2*DATA_W-1:DATA_W]};
          op_b = {1'b0, mag_b};
          sub  = 1'b1;
        end else begin
          sub = (req.op == ALU_SUB);
        end
      end
      ALU_MULT: begin
        op_a = {1'b0, work[2*DATA_W-1:DATA_W]};
        op_b = {1'b0, opnd};
      end
      ALU_DIVIDE: begin
        op_a = work[2*DATA_W-1:DATA_W-1];
        op_b = {1'b0, opnd};
        sub  = 1'b1;
      end
      ALU_FIN: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // One add/subtract serves every operation
  assign sum    = {1'b0, op_a} + ({1'b0, op_b} ^ {(DATA_W+2){sub}}) + (DATA_W+2)'(sub);
  assign borrow = sum[DATA_W+1];

  // Final magnitude and saturation check
  assign mag = is_mul ? (work >> FRACTION_BITS)
                      : {{(DATA_W-1){1'b0}}, ovf, work[DATA_W-1:0]};
  assign sat = |mag[2*DATA_W-1:DATA_W-1];

  // Sequencing of the unit
  always_comb begin
    state_next  = state;
    step_next   = step;
    work_next   = work;
    opnd_next   = opnd;
    neg_next    = neg;
    ovf_next    = ovf;
    is_mul_next = is_mul;
    done_next   = 1'b0;
    res_next    = res;
    unique case (state)
      ALU_IDLE: begin
        if (req.start) begin
          neg_next  = a[DATA_W-1] ^ b[DATA_W-1];
          step_next = '0;
          unique case (req.op)
            ALU_ADD, ALU_SUB: begin
              if (sum[DATA_W] != sum[DATA_W-1]) begin
                res_next = sum[DATA_W] ? SAT_MIN : SAT_MAX;
              end else begin
                res_next = sum[DATA_W-1:0];
              end
              done_next = 1'b1;
            end
            ALU_MUL: begin
              work_next   = {{DATA_W{1'b0}}, mag_b};
              opnd_next   = mag_a;
              is_mul_next = 1'b1;
              state_next  = ALU_MULT;
            end
            ALU_DIV: begin
              work_next   = num;
              opnd_next   = mag_b;
              ovf_next    = ~borrow;
              is_mul_next = 1'b0;
              state_next  = ALU_DIVIDE;
            end
          endcase
        end
      end
      ALU_MULT: begin
        // shift-add, one multiplier bit a cycle
        if (work[0]) begin
          work_next = {sum[DATA_W:0], work[DATA_W-1:1]};
        end else begin
          work_next = {1'b0, work[2*DATA_W-1:1]};
        end
        step_next = step + 1'b1;
        if (step == STEP_W'(ALU_STEPS-1)) begin
          state_next = ALU_FIN;
        end
      end
      ALU_DIVIDE: begin
        // restoring divide, one quotient bit a cycle
        if (borrow) begin
          work_next = {work[2*DATA_W-2:0], 1'b0};
        end else begin
          work_next = {sum[DATA_W-1:0], work[DATA_W-2:0], 1'b1};
        end
        step_next = step + 1'b1;
        if (step == STEP_W'(ALU_STEPS-1)) begin
          state_next = ALU_FIN;
        end
      end
      ALU_FIN: begin
        if (sat) begin
          res_next = neg ? SAT_MIN : SAT_MAX;
        end else if (neg) begin
          res_next = DATA_W'(-mag[DATA_W-1:0]);
        end else begin
          res_next = mag[DATA_W-1:0];
        end
        done_next  = 1'b1;
        state_next = ALU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ALU_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    step   <= step_next;
    work   <= work_next;
    opnd   <= opnd_next;
    neg    <= neg_next;
    ovf    <= ovf_next;
    is_mul <= is_mul_next;
    res    <= res_next;
  end

endmodule

// ===== hw/rtl/rpn_stack_evaluator.sv =====
// Reverse Polish evaluator on signed fixed point (FRACTION_BITS fraction bits) with a
// STACK_DEPTH-entry operand stack. One token word is taken at a time. A number, an
// invalid token, an operator that underflows or any token after an error is handled in
// the accept cycle alone. Add and subtract go through the accept cycle, two stack reads,
// an issue step and a write-back. Multiply and divide take the same steps plus the
// shared arithmetic unit's iterations, one multiplier or quotient bit per cycle, and a
// final step to sign and saturate. A divide by zero is caught at the issue cycle.
// End of expression waits until the output slot is free and then gives one result word
// (status and answer). The next token is accepted while that result word still waits to
// be taken, but a further end of expression holds until the word has gone. Errors stick
// until end of expression.
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       token_valid,
  output logic                       token_ready,
  input  logic [KIND_W-1:0]          kind,
  input  logic signed [DATA_W-1:0]   value,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [STATUS_W-1:0]        status,
  output logic signed [DATA_W-1:0]   answer
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  seq_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  status_t err, err_next;
  alu_op_t op, op_next;
  logic signed [DATA_W-1:0] right, right_next;
  logic result_valid_next;
  status_t status_q, status_next;
  logic signed [DATA_W-1:0] answer_q, answer_next;

  logic [CW-1:0] cm1, cm2;
  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data, rd_data;
  alu_req_t alu_req;
  logic alu_done;
  logic signed [DATA_W-1:0] alu_res;

  assign cm1 = count - 1'b1;
  assign cm2 = count - CW'(2);

  rpn_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpn_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (rd_data),
    .b    (right),
    .done (alu_done),
    .res  (alu_res)
  );

  assign token_ready = (state == S_IDLE);
  assign status      = status_q;
  assign answer      = answer_q;

  // Token sequencer
  always_comb begin
    state_next        = state;
    count_next        = count;
    err_next          = err;
    op_next           = op;
    right_next        = right;
    status_next       = status_q;
    answer_next       = answer_q;
    result_valid_next = result_valid && !result_ready;
    wr_en             = 1'b0;
    wr_addr           = count[AW-1:0];
    wr_data           = value;
    rd_addr           = '0;
    alu_req.start     = 1'b0;
    alu_req.op        = op;
    unique case (state)
      S_IDLE: begin
        if (token_valid) begin
          if (kind == K_END) begin
            state_next = S_END;
          end else if (err == ST_OK) begin
            unique case (kind)
              K_NUM: begin
                if (count == CW'(STACK_DEPTH)) begin
                  err_next = ST_OVERFLOW;
                end else begin
                  wr_en      = 1'b1;
                  count_next = count + 1'b1;
                end
              end
              K_ADD, K_SUB, K_MUL, K_DIV: begin
                if (count < CW'(2)) begin
                  err_next = ST_UNDERFLOW;
                end else begin
                  unique case (kind)
                    K_ADD:   op_next = ALU_ADD;
                    K_SUB:   op_next = ALU_SUB;
                    K_MUL:   op_next = ALU_MUL;
                    default: op_next = ALU_DIV;
                  endcase
                  state_next = S_RD_R;
                end
              end
              default: err_next = ST_INVALID;
            endcase
          end
        end
      end
      S_RD_R: begin
        rd_addr    = cm1[AW-1:0];
        state_next = S_RD_L;
      end
      S_RD_L: begin
        right_next = rd_data;
        rd_addr    = cm2[AW-1:0];
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // left operand is on the read port now
        if (op == ALU_DIV && right == '0) begin
          err_next   = ST_DIV_ZERO;
          state_next = S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_next    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          wr_en      = 1'b1;
          wr_addr    = cm2[AW-1:0];
          wr_data    = alu_res;
          count_next = cm1;
          state_next = S_IDLE;
        end
      end
      S_END: begin
        // bottom entry is on the read port; load once the output slot is free
        if (!result_valid || result_ready) begin
          answer_next = '0;
          if (err != ST_OK) begin
            status_next = err;
          end else if (count > CW'(1)) begin
            status_next = ST_TOO_MANY;
          end else if (count == '0) begin
            status_next = ST_TOO_FEW;
          end else begin
            status_next = ST_OK;
            answer_next = rd_data;
          end
          result_valid_next = 1'b1;
          count_next        = '0;
          err_next          = ST_OK;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      err          <= err_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    right    <= right_next;
    status_q <= status_next;
    answer_q <= answer_next;
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpn_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOKEN_TARGET = 1450;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;

  // kind code outside the defined set, must be treated as an invalid token
  localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

  localparam logic signed [DATA_W-1:0] ONE_Q      = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] NEG_HALF_Q = 32'shFFFF_8000;

  typedef struct {
    status_t                  st;
    logic signed [DATA_W-1:0] ans;
  } result_t;

  typedef struct {
    logic [KIND_W-1:0]        k;
    logic signed [DATA_W-1:0] v;
    bit                       typed;
    status_t                  st;
    logic signed [DATA_W-1:0] ans;
  } token_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     token_valid;
  logic                     token_ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic                     result_valid;
  logic                     result_ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] answer;

  // Evaluator state as seen by the predictor
  logic signed [DATA_W-1:0] operands [STACK_DEPTH_DEF];
  int                       operand_count = 0;
  status_t                  held_error = ST_OK;

  result_t awaited_words [$];
  int      fails = 0;
  int      tokens_sent = 0;
  int      cycles = 0;
  bit      tok_calm = 1'b0;
  bit      res_calm = 1'b0;

  // Directed tokens: saturation, every error but stack overflow, both end-count cases
  localparam int N_DIRECTED = 29;
  token_row_t directed [N_DIRECTED] = '{
    '{K_END,     '0,         1'b1, ST_TOO_FEW,   '0},
    '{K_NUM,     SAT_MAX,    1'b0, ST_OK,        '0},
    '{K_NUM,     SAT_MAX,    1'b0, ST_OK,        '0},
    '{K_ADD,     '0,         1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b1, ST_OK,        SAT_MAX},
    '{K_NUM,     SAT_MIN,    1'b0, ST_OK,        '0},
    '{K_NUM,     ONE_Q,      1'b0, ST_OK,        '0},
    '{K_SUB,     '0,         1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b1, ST_OK,        SAT_MIN},
    '{K_NUM,     SAT_MIN,    1'b0, ST_OK,        '0},
    '{K_NUM,     SAT_MIN,    1'b0, ST_OK,        '0},
    '{K_MUL,     '0,         1'b0, ST_OK,        '0},
    '{K_NUM,     NEG_HALF_Q, 1'b0, ST_OK,        '0},
    '{K_DIV,     '0,         1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b0, ST_OK,        '0},
    '{K_ADD,     '0,         1'b0, ST_OK,        '0},
    '{K_NUM,     ONE_Q,      1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b1, ST_UNDERFLOW, '0},
    '{K_NUM,     ONE_Q,      1'b0, ST_OK,        '0},
    '{K_NUM,     '0,         1'b0, ST_OK,        '0},
    '{K_DIV,     '0,         1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b1, ST_DIV_ZERO,  '0},
    '{K_INVALID, '0,         1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b1, ST_INVALID,   '0},
    '{K_UNUSED,  '0,         1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b1, ST_INVALID,   '0},
    '{K_NUM,     ONE_Q,      1'b0, ST_OK,        '0},
    '{K_NUM,     ONE_Q,      1'b0, ST_OK,        '0},
    '{K_END,     '0,         1'b1, ST_TOO_MANY,  '0}
  };

  rpn_stack_evaluator dut (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .kind         (kind),
    .value        (value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .answer       (answer)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Saturate a wide sum to the signed word range
  function automatic logic signed [DATA_W-1:0] clamp_word(input longint x);
    if (x > longint'(SAT_MAX)) return SAT_MAX;
    if (x < longint'(SAT_MIN)) return SAT_MIN;
    return DATA_W'(x);
  endfunction

  // Apply a sign to a magnitude, saturating at either end
  function automatic logic signed [DATA_W-1:0] signed_mag(input longint mag, input bit neg);
    longint lim;
    lim = neg ? 64'sh8000_0000 : longint'(SAT_MAX);
    if (mag > lim) mag = lim;
    return neg ? DATA_W'(-mag) : DATA_W'(mag);
  endfunction

  // Advance the predicted evaluator by one token; returns 1 when a result word is due
  function automatic bit apply_token(input logic [KIND_W-1:0] k,
                                     input logic signed [DATA_W-1:0] v, output result_t r);
    logic signed [DATA_W-1:0] lhs, rhs, res;
    longint prod, quo;
    r.st  = ST_OK;
    r.ans = '0;
    if (k == K_END) begin
      r.st = held_error;
      if (held_error == ST_OK) begin
        if (operand_count > 1) r.st = ST_TOO_MANY;
        else if (operand_count == 0) r.st = ST_TOO_FEW;
        else r.ans = operands[0];
      end
      operand_count = 0;
      held_error    = ST_OK;
      return 1'b1;
    end
    // anything after an error is swallowed until end of expression
    if (held_error != ST_OK) return 1'b0;
    case (k)
      K_NUM: begin
        if (operand_count >= STACK_DEPTH_DEF) begin
          held_error = ST_OVERFLOW;
        end else begin
          operands[operand_count] = v;
          operand_count++;
        end
      end
      K_ADD, K_SUB, K_MUL, K_DIV: begin
        if (operand_count < 2) begin
          held_error = ST_UNDERFLOW;
        end else begin
          rhs = operands[operand_count-1];
          lhs = operands[operand_count-2];
          if (k == K_DIV && rhs == 0) begin
            held_error = ST_DIV_ZERO;
          end else begin
            case (k)
              K_ADD: res = clamp_word(longint'(lhs) + longint'(rhs));
              K_SUB: res = clamp_word(longint'(lhs) - longint'(rhs));
              K_MUL: begin
                prod = longint'(lhs) * longint'(rhs);
                res  = signed_mag((prod < 0 ? -prod : prod) >> FRACTION_BITS_DEF, prod < 0);
              end
              default: begin
                quo = ((lhs < 0 ? -longint'(lhs) : longint'(lhs)) << FRACTION_BITS_DEF) /
                      (rhs < 0 ? -longint'(rhs) : longint'(rhs));
                res = signed_mag(quo, (lhs < 0) != (rhs < 0));
              end
            endcase
            operand_count--;
            operands[operand_count-1] = res;
          end
        end
      end
      default: held_error = ST_INVALID;
    endcase
    return 1'b0;
  endfunction

  // Operand mix: extremes, small values around zero, and full-range noise
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return '0;
      3:       return ONE_Q;
      4:       return -ONE_Q;
      5, 6, 7, 8, 9: return DATA_W'(int'($urandom_range(0, 'h80000)) - 'h40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_operator();
    return kind_t'($urandom_range(int'(K_ADD), int'(K_DIV)));
  endfunction

  // Offer one token word, then log what the evaluator should answer
  task automatic send_token(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v,
                            input bit typed, input status_t st,
                            input logic signed [DATA_W-1:0] ans);
    int      gap;
    result_t r;
    gap = tok_calm ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) tok_calm = !tok_calm;
    if (gap > 0) begin
      token_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token_valid <= 1'b1;
    kind        <= k;
    value       <= v;
    do @(posedge clk); while (!token_ready);
    tokens_sent++;
    if (apply_token(k, v, r)) begin
      if (typed) begin
        r.st  = st;
        r.ans = ans;
      end
      awaited_words.push_back(r);
    end
  endtask

  task automatic send_plain(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
    send_token(k, v, 1'b0, ST_OK, '0);
  endtask

  // Well-formed postfix expression over the given number of operands
  task automatic send_expression(input int n_operands);
    int to_push, depth;
    to_push = n_operands;
    depth   = 0;
    while (to_push > 0 || depth > 1) begin
      if (depth >= 2 && (to_push == 0 || $urandom_range(0, 2) == 0)) begin
        send_plain(pick_operator(), $urandom);
        depth--;
      end else begin
        send_plain(K_NUM, pick_value());
        to_push--;
        depth++;
      end
    end
    send_plain(K_END, $urandom);
  endtask

  // Main stimulus
  initial begin
    int r, len;
    token_valid <= 1'b0;
    kind        <= K_NUM;
    value       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_token(directed[i].k, directed[i].v, directed[i].typed, directed[i].st,
                 directed[i].ans);

    while (tokens_sent < TOKEN_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_expression($urandom_range(8, STACK_DEPTH_DEF));
      end else if (r < 75) begin
        send_expression($urandom_range(1, 6));
      end else if (r < 90) begin
        // loose tokens of any kind, end included
        len = $urandom_range(0, 20);
        repeat (len) send_plain(kind_t'($urandom_range(0, 7)), pick_value());
        send_plain(K_END, $urandom);
      end else begin
        // fill the stack to the brim and at times beyond
        len = STACK_DEPTH_DEF + $urandom_range(0, 3);
        repeat (len) send_plain(K_NUM, pick_value());
        repeat ($urandom_range(0, 3)) send_plain(pick_operator(), $urandom);
        send_plain(K_END, $urandom);
      end
    end
    token_valid <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("rpn_stack_evaluator verification clean");
    else
      $display("rpn_stack_evaluator verification failed");
    $finish;
  end

  // Result side: random back-pressure, sometimes only once a word is showing
  initial begin
    int stall;
    bit hold_first;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall      = res_calm ? 0 : $urandom_range(0, 8);
      hold_first = !res_calm && $urandom_range(0, 1);
      if ($urandom_range(0, 39) == 0) res_calm = !res_calm;
      if (hold_first || stall > 0) result_ready <= 1'b0;
      if (hold_first) do @(posedge clk); while (!result_valid);
      repeat (stall) @(posedge clk);
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  // Compare each result word against the oldest prediction
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid && result_ready) begin
      if (awaited_words.size() == 0) begin
        if (fails < MAX_REPORTS)
          $display("unexpected result word: status %0d answer %h", status, answer);
        fails++;
      end else begin
        w = awaited_words.pop_front();
        if (status !== w.st || answer !== w.ans) begin
          if (fails < MAX_REPORTS)
            $display("result mismatch: status exp %0d got %0d, answer exp %h got %h",
                     w.st, status, w.ans, answer);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rpn_stack_evaluator verification failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_stack.sv
hw/rtl/rpn_alu.sv
hw/rtl/rpn_stack_evaluator.sv
bench/tb.sv
